FILE: rtl/dca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the DMA cycle arbiter.
// No dependencies; the arbiter and the testbench refer to this package by scoped names.
package dca_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_TICK           = 2'd0;
  localparam logic [1:0] REQ_OAM_START      = 2'd1;
  localparam logic [1:0] REQ_SAMPLE_RESTART = 2'd2;

  // Read kinds reported in read_kind.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_DUMMY  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;
  localparam logic [1:0] KIND_OAM    = 2'd3;

  // Address constants.
  localparam logic [15:0] ADDR_TOP     = 16'hFFFF;
  localparam logic [15:0] ADDR_WRAP    = 16'h8000;
  localparam logic [15:0] ADDR_NODUMMY = 16'h2007;

  // Halt lengths for a sample fetch started on a get or a put cycle.
  localparam logic [2:0] HALT_GET = 3'd4;
  localparam logic [2:0] HALT_PUT = 3'd3;

  // Sprite DMA sequencer states.
  typedef enum logic [1:0] {
    OAM_ALIGN = 2'd0,
    OAM_WAIT  = 2'd1,
    OAM_READ  = 2'd2,
    OAM_WRITE = 2'd3
  } oam_phase_t;

  // Payload of one request transaction.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  dma_page;
    logic        dpcm_pending;
    logic        dpcm_enabled;
    logic        implicit_abort;
    logic        cpu_writing;
    logic [15:0] cpu_address;
    logic [7:0]  read_data;
    logic [15:0] sample_address;
    logic [11:0] sample_length;
    logic        loop_enable;
    logic        irq_enable;
  } dca_req_t;

  // Payload of one result transaction.
  typedef struct packed {
    logic        cpu_run;
    logic [1:0]  read_kind;
    logic [15:0] bus_address;
    logic        oam_write;
    logic [7:0]  oam_data;
    logic        dpcm_irq;
    logic        dpcm_ack;
    logic        abort_clear;
  } dca_res_t;

endpackage

FILE: rtl/dca_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface with a typed payload.
// Used with the payload structs of dca_pkg.
interface dca_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dma_cycle_arbiter.sv
`timescale 1ns / 1ps
// Per-cycle arbiter between the CPU, sample DMA and sprite DMA.
// Depends on dca_pkg and dca_stream_if.
//
// Usage: req carries one transaction per emulated CPU cycle (a tick), or a
// sprite DMA start, or a sample channel restart. For every tick the block
// returns exactly one transaction on res that tells whether the CPU runs,
// which read the block issues, and any sprite memory write, interrupt or
// acknowledge. Start and restart transactions return nothing.
// Data for a read issued on one tick comes back in read_data of the next.
// A transaction is registered on acceptance, and a tick's result is
// registered from it into the result register once that register is free.
// Throughput: one transaction per clock unless res stalls; the whole decision
// for a tick is one pass of logic between the request and result registers.
// Reset (synchronous, rst high) empties both registers, sets the parity to a
// get cycle, stops both DMA channels and points the sample address at 0x8000.
// When res is stalled, the held result stays put; starts and restarts still
// pass; a tick waits in the request register, with req.ready low until res moves.
module dma_cycle_arbiter (
  input  logic         clk,
  input  logic         rst,
  dca_stream_if.sink   req,
  dca_stream_if.source res
);

  // Request register.
  logic              req_valid;
  dca_pkg::dca_req_t req_q;

  // Result register.
  logic              res_valid;
  dca_pkg::dca_res_t res_q;

  // Arbiter state.
  logic                cycle_parity, cycle_parity_next;
  logic                dpcm_active, dpcm_active_next;
  logic [2:0]          halt_count, halt_count_next;
  logic [15:0]         dpcm_address, dpcm_address_next;
  logic [11:0]         dpcm_remaining, dpcm_remaining_next;
  logic                oam_busy, oam_busy_next;
  dca_pkg::oam_phase_t oam_phase, oam_phase_next;
  logic [7:0]          oam_page, oam_page_next;
  logic [7:0]          oam_offset, oam_offset_next;
  logic [7:0]          oam_latch, oam_latch_next;
  logic                oam_read_due, oam_read_due_next;

  dca_pkg::dca_res_t res_next;

  // Handshake control.
  logic is_tick;
  logic slot_free;
  logic fire;

  // Shared decode of the registered request.
  logic        is_get;
  logic        dpcm_req;
  logic        dpcm_start;
  logic        active_eff;
  logic [2:0]  halt_eff;
  logic        fetch;
  logic [15:0] addr_inc;
  logic [11:0] remaining_dec;
  logic [7:0]  latch_eff;
  logic [7:0]  offset_inc;

  assign is_tick   = (req_q.req_type == dca_pkg::REQ_TICK);
  assign slot_free = !res_valid || res.ready;
  assign fire      = req_valid && (!is_tick || slot_free);

  assign req.ready = !req_valid || fire;
  assign res.valid = res_valid;
  assign res.data  = res_q;

  // A sample request is seen only when no sample halt is in progress.
  assign is_get        = !cycle_parity;
  assign dpcm_req      = req_q.dpcm_pending && !dpcm_active;
  assign dpcm_start    = dpcm_req && !req_q.cpu_writing &&
                         (req_q.dpcm_enabled || req_q.implicit_abort);
  assign active_eff    = dpcm_active || dpcm_start;
  assign halt_eff      = dpcm_start ? (is_get ? dca_pkg::HALT_GET : dca_pkg::HALT_PUT)
                                    : halt_count;
  assign fetch         = active_eff && (halt_eff == 3'd1);
  assign addr_inc      = (dpcm_address == dca_pkg::ADDR_TOP) ? dca_pkg::ADDR_WRAP
                                                             : dpcm_address + 16'd1;
  assign remaining_dec = dpcm_remaining - 12'd1;
  assign latch_eff     = oam_read_due ? req_q.read_data : oam_latch;
  assign offset_inc    = oam_offset + 8'd1;

  // Next state of the arbiter for the request in the register.
  always_comb begin
    cycle_parity_next   = cycle_parity;
    dpcm_active_next    = dpcm_active;
    halt_count_next     = halt_count;
    dpcm_address_next   = dpcm_address;
    dpcm_remaining_next = dpcm_remaining;
    oam_busy_next       = oam_busy;
    oam_phase_next      = oam_phase;
    oam_page_next       = oam_page;
    oam_offset_next     = oam_offset;
    oam_latch_next      = oam_latch;
    oam_read_due_next   = oam_read_due;
    unique case (req_q.req_type)
      dca_pkg::REQ_OAM_START: begin
        oam_busy_next   = 1'b1;
        oam_phase_next  = dca_pkg::OAM_ALIGN;
        oam_page_next   = req_q.dma_page;
        oam_offset_next = 8'd0;
      end
      dca_pkg::REQ_SAMPLE_RESTART: begin
        dpcm_address_next   = req_q.sample_address;
        dpcm_remaining_next = req_q.sample_length;
      end
      dca_pkg::REQ_TICK: begin
        cycle_parity_next = !cycle_parity;
        oam_latch_next    = latch_eff;
        oam_read_due_next = 1'b0;
        if (active_eff) begin
          dpcm_active_next = !fetch;
          halt_count_next  = halt_eff - 3'd1;
          if (fetch) begin
            dpcm_address_next = addr_inc;
            if (dpcm_remaining != 12'd0) begin
              dpcm_remaining_next = remaining_dec;
              if (remaining_dec == 12'd0 && req_q.loop_enable) begin
                dpcm_address_next   = req_q.sample_address;
                dpcm_remaining_next = req_q.sample_length;
              end
            end
          end
        end else if (oam_busy) begin
          unique case (oam_phase)
            dca_pkg::OAM_ALIGN: begin
              oam_phase_next = is_get ? dca_pkg::OAM_WAIT : dca_pkg::OAM_READ;
            end
            dca_pkg::OAM_WAIT: begin
              oam_phase_next = dca_pkg::OAM_READ;
            end
            dca_pkg::OAM_READ: begin
              if (is_get) begin
                oam_phase_next    = dca_pkg::OAM_WRITE;
                oam_read_due_next = 1'b1;
              end
            end
            dca_pkg::OAM_WRITE: begin
              if (!is_get) begin
                oam_offset_next = offset_inc;
                if (offset_inc == 8'd0) begin
                  oam_busy_next = 1'b0;
                end else begin
                  oam_phase_next = dca_pkg::OAM_READ;
                end
              end
            end
            default: begin
              oam_phase_next = oam_phase;
            end
          endcase
        end
      end
      default: begin
        cycle_parity_next = cycle_parity;
      end
    endcase
  end

  // Result fields for a tick.
  always_comb begin
    res_next             = '0;
    res_next.dpcm_ack    = dpcm_req && !req_q.cpu_writing;
    res_next.abort_clear = dpcm_req && req_q.cpu_writing && req_q.implicit_abort;
    if (active_eff) begin
      if (fetch) begin
        res_next.read_kind   = dca_pkg::KIND_SAMPLE;
        res_next.bus_address = dpcm_address;
        res_next.dpcm_irq    = (dpcm_remaining == 12'd1) && !req_q.loop_enable &&
                               req_q.irq_enable;
      end else if (req_q.cpu_address != dca_pkg::ADDR_NODUMMY) begin
        res_next.read_kind   = dca_pkg::KIND_DUMMY;
        res_next.bus_address = req_q.cpu_address;
      end
    end else if (oam_busy) begin
      if (oam_phase == dca_pkg::OAM_READ && is_get) begin
        res_next.read_kind   = dca_pkg::KIND_OAM;
        res_next.bus_address = {oam_page, oam_offset};
      end else if (oam_phase == dca_pkg::OAM_WRITE && !is_get) begin
        res_next.oam_write = 1'b1;
        res_next.oam_data  = latch_eff;
      end
    end else begin
      res_next.cpu_run = 1'b1;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      req_q <= req.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && is_tick) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (fire && is_tick) begin
      res_q <= res_next;
    end
  end

  // Arbiter state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_parity   <= 1'b0;
      dpcm_active    <= 1'b0;
      halt_count     <= 3'd0;
      dpcm_address   <= dca_pkg::ADDR_WRAP;
      dpcm_remaining <= 12'd0;
      oam_busy       <= 1'b0;
      oam_phase      <= dca_pkg::OAM_ALIGN;
      oam_page       <= 8'd0;
      oam_offset     <= 8'd0;
      oam_latch      <= 8'd0;
      oam_read_due   <= 1'b0;
    end else if (fire) begin
      cycle_parity   <= cycle_parity_next;
      dpcm_active    <= dpcm_active_next;
      halt_count     <= halt_count_next;
      dpcm_address   <= dpcm_address_next;
      dpcm_remaining <= dpcm_remaining_next;
      oam_busy       <= oam_busy_next;
      oam_phase      <= oam_phase_next;
      oam_page       <= oam_page_next;
      oam_offset     <= oam_offset_next;
      oam_latch      <= oam_latch_next;
      oam_read_due   <= oam_read_due_next;
    end
  end

  // While a sample halt runs, the counter stays between one and four.
  a_halt_range: assert property (@(posedge clk) disable iff (rst)
    dpcm_active |-> (halt_count >= 3'd1 && halt_count <= dca_pkg::HALT_GET))
    else $error("halt counter out of range during sample halt");

  // The tick that reaches the end of a halt releases the CPU.
  a_halt_end: assert property (@(posedge clk) disable iff (rst)
    fire && is_tick && dpcm_active && halt_count == 3'd1 |=> !dpcm_active)
    else $error("sample halt did not end after the fetch");

  // Every tick leaves a result and flips the parity.
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    fire && is_tick |=> res_valid && (cycle_parity != $past(cycle_parity)))
    else $error("tick transaction without result or parity flip");

  // Start and restart transactions add no result.
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    fire && !is_tick |=> res_valid == $past(res_valid && !res.ready))
    else $error("non-tick transaction produced a result");

endmodule

FILE: bench/tb_dma_cycle_arbiter.sv
`timescale 1ns / 1ps
// Self-checking testbench for dma_cycle_arbiter: directed and random request traffic,
// a cycle-level predictor of the CPU/sample/sprite DMA arbitration, and a result scoreboard.
// Depends on dca_pkg, dca_stream_if and the dma_cycle_arbiter RTL.
module tb_dma_cycle_arbiter;

  // Request code that the block must drop without a result.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTED = 40;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   src_idle_pct = 15;
  int   sink_idle_pct = 70;

  // Sample setup carried on every transaction, changed by restarts.
  logic [15:0] smp_addr = dca_pkg::ADDR_WRAP;
  logic [11:0] smp_len = '0;
  logic        smp_loop = 1'b0;
  logic        smp_irq = 1'b0;

  dca_stream_if #(.payload_t(dca_pkg::dca_req_t)) req_if ();
  dca_stream_if #(.payload_t(dca_pkg::dca_res_t)) res_if ();

  dma_cycle_arbiter dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if)
  );

  // Predicts the arbitration decision of every tick and checks results in order.
  class dca_scoreboard;
    bit                  put_cycle;
    bit                  dpcm_busy;
    logic [2:0]          halt_left;
    logic [15:0]         smp_ptr;
    logic [11:0]         smp_left;
    bit                  oam_busy;
    dca_pkg::oam_phase_t oam_phase;
    logic [7:0]          oam_page;
    logic [7:0]          oam_offset;
    logic [7:0]          oam_latch;
    bit                  oam_read_due;
    dca_pkg::dca_res_t   due_results[$];
    int                  errors;
    int                  result_idx;

    function new();
      put_cycle = 1'b0;
      dpcm_busy = 1'b0;
      halt_left = '0;
      smp_ptr = dca_pkg::ADDR_WRAP;
      smp_left = '0;
      oam_busy = 1'b0;
      oam_phase = dca_pkg::OAM_ALIGN;
      oam_page = '0;
      oam_offset = '0;
      oam_latch = '0;
      oam_read_due = 1'b0;
      errors = 0;
      result_idx = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Applies one accepted request transaction and queues the decision of a tick.
    function void note_request(dca_pkg::dca_req_t r);
      dca_pkg::dca_res_t o;
      bit                get;
      o = '0;
      if (r.req_type == dca_pkg::REQ_OAM_START) begin
        oam_busy = 1'b1;
        oam_phase = dca_pkg::OAM_ALIGN;
        oam_page = r.dma_page;
        oam_offset = '0;
        return;
      end
      if (r.req_type == dca_pkg::REQ_SAMPLE_RESTART) begin
        smp_ptr = r.sample_address;
        smp_left = r.sample_length;
        return;
      end
      if (r.req_type != dca_pkg::REQ_TICK) return;
      get = !put_cycle;

      // Data for a sprite source read arrives with the first tick after it.
      if (oam_read_due) begin
        oam_latch = r.read_data;
        oam_read_due = 1'b0;
      end

      // A new sample request is only looked at while no halt is running.
      if (r.dpcm_pending && !dpcm_busy) begin
        if (!r.cpu_writing) begin
          if (r.dpcm_enabled || r.implicit_abort) begin
            dpcm_busy = 1'b1;
            halt_left = get ? dca_pkg::HALT_GET : dca_pkg::HALT_PUT;
          end
          o.dpcm_ack = 1'b1;
        end else if (r.implicit_abort) begin
          o.abort_clear = 1'b1;
        end
      end

      if (dpcm_busy) begin
        // Last halt cycle fetches the sample byte; earlier ones re-read the CPU address.
        if (halt_left == 3'd1) begin
          o.read_kind = dca_pkg::KIND_SAMPLE;
          o.bus_address = smp_ptr;
          smp_ptr = (smp_ptr == dca_pkg::ADDR_TOP) ? dca_pkg::ADDR_WRAP : smp_ptr + 16'd1;
          if (smp_left != '0) begin
            smp_left = smp_left - 12'd1;
            if (smp_left == '0) begin
              if (r.loop_enable) begin
                smp_ptr = r.sample_address;
                smp_left = r.sample_length;
              end else if (r.irq_enable) begin
                o.dpcm_irq = 1'b1;
              end
            end
          end
          dpcm_busy = 1'b0;
        end else if (r.cpu_address != dca_pkg::ADDR_NODUMMY) begin
          o.read_kind = dca_pkg::KIND_DUMMY;
          o.bus_address = r.cpu_address;
        end
        halt_left = halt_left - 3'd1;
      end else if (oam_busy) begin
        // Sprite DMA reads on get cycles and writes on put cycles.
        case (oam_phase)
          dca_pkg::OAM_ALIGN: oam_phase = get ? dca_pkg::OAM_WAIT : dca_pkg::OAM_READ;
          dca_pkg::OAM_WAIT:  oam_phase = dca_pkg::OAM_READ;
          dca_pkg::OAM_READ: begin
            if (get) begin
              o.read_kind = dca_pkg::KIND_OAM;
              o.bus_address = {oam_page, oam_offset};
              oam_read_due = 1'b1;
              oam_phase = dca_pkg::OAM_WRITE;
            end
          end
          default: begin
            if (!get) begin
              o.oam_write = 1'b1;
              o.oam_data = oam_latch;
              oam_offset = oam_offset + 8'd1;
              if (oam_offset == '0) oam_busy = 1'b0;
              else oam_phase = dca_pkg::OAM_READ;
            end
          end
        endcase
      end else begin
        o.cpu_run = 1'b1;
      end
      put_cycle = !put_cycle;
      due_results.push_back(o);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task diff(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", result_idx, name, got, want));
    endtask

    // Compares one accepted result transaction with the oldest prediction.
    task check_result(dca_pkg::dca_res_t got);
      dca_pkg::dca_res_t w;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d arrived with no tick outstanding", result_idx));
      end else begin
        w = due_results.pop_front();
        diff("cpu_run", got.cpu_run, w.cpu_run);
        diff("read_kind", got.read_kind, w.read_kind);
        diff("bus_address", got.bus_address, w.bus_address);
        diff("oam_write", got.oam_write, w.oam_write);
        diff("oam_data", got.oam_data, w.oam_data);
        diff("dpcm_irq", got.dpcm_irq, w.dpcm_irq);
        diff("dpcm_ack", got.dpcm_ack, w.dpcm_ack);
        diff("abort_clear", got.abort_clear, w.abort_clear);
      end
      result_idx++;
    endtask
  endclass

  dca_scoreboard arb_sb = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watch both channels; a request is noted before a result of the same edge is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) arb_sb.note_request(req_if.data);
      if (res_if.valid && res_if.ready) arb_sb.check_result(res_if.data);
    end
  end

  // Result side stalls at random.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Builds a tick with the given sample flags and CPU address; page and read data random.
  function automatic dca_pkg::dca_req_t tick_with(bit pend, bit en, bit abrt, bit wr,
                                                  logic [15:0] addr);
    dca_pkg::dca_req_t t;
    t.req_type = dca_pkg::REQ_TICK;
    t.dma_page = 8'($urandom);
    t.dpcm_pending = pend;
    t.dpcm_enabled = en;
    t.implicit_abort = abrt;
    t.cpu_writing = wr;
    t.cpu_address = addr;
    t.read_data = 8'($urandom);
    t.sample_address = smp_addr;
    t.sample_length = smp_len;
    t.loop_enable = smp_loop;
    t.irq_enable = smp_irq;
    return t;
  endfunction

  function automatic dca_pkg::dca_req_t rand_tick(int pend_pct);
    logic [15:0] addr;
    addr = ($urandom_range(7) == 0) ? dca_pkg::ADDR_NODUMMY : 16'($urandom);
    return tick_with($urandom_range(99) < pend_pct, $urandom_range(3) != 0,
                     $urandom_range(3) == 0, $urandom_range(3) == 0, addr);
  endfunction

  function automatic dca_pkg::dca_req_t sample_restart();
    dca_pkg::dca_req_t t;
    t = rand_tick(50);
    t.req_type = dca_pkg::REQ_SAMPLE_RESTART;
    return t;
  endfunction

  function automatic dca_pkg::dca_req_t oam_start(logic [7:0] page);
    dca_pkg::dca_req_t t;
    t = rand_tick(50);
    t.req_type = dca_pkg::REQ_OAM_START;
    t.dma_page = page;
    return t;
  endfunction

  // Picks a new sample setup; lengths are mostly short so that samples end often.
  function automatic dca_pkg::dca_req_t new_sample();
    case ($urandom_range(3))
      0: smp_addr = dca_pkg::ADDR_TOP;
      1: smp_addr = dca_pkg::ADDR_TOP - 16'd1;
      default: smp_addr = 16'($urandom);
    endcase
    smp_len = ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(3));
    smp_loop = 1'($urandom_range(1));
    smp_irq = 1'($urandom_range(1));
    return sample_restart();
  endfunction

  // Offers one transaction after a random gap and waits until it is taken.
  task automatic send(dca_pkg::dca_req_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= item;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Holds the request side idle until every predicted result has been checked.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (arb_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic directed_run();
    dca_pkg::dca_req_t t;
    smp_addr = dca_pkg::ADDR_TOP;
    smp_len = 12'd2;
    smp_loop = 1'b0;
    smp_irq = 1'b1;
    send(tick_with(1'b0, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    // An unused request code carrying a sample request must be dropped.
    t = tick_with(1'b1, 1'b1, 1'b0, 1'b0, 16'($urandom));
    t.req_type = REQ_UNUSED;
    send(t);
    send(sample_restart());
    // Put-cycle request: short halt, no dummy read at the data port, fetch wraps the address.
    send(tick_with(1'b1, 1'b1, 1'b0, 1'b0, dca_pkg::ADDR_NODUMMY));
    send(tick_with(1'b1, 1'b1, 1'b0, 1'b0, dca_pkg::ADDR_TOP));
    send(tick_with(1'b1, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    // CPU writing with abort set, then a disabled request with no abort.
    send(tick_with(1'b1, 1'b0, 1'b1, 1'b1, 16'($urandom)));
    send(tick_with(1'b1, 1'b0, 1'b0, 1'b0, 16'($urandom)));
    // Disabled but aborting on a get cycle: long halt, last byte raises the interrupt.
    send(tick_with(1'b1, 1'b0, 1'b1, 1'b0, 16'($urandom)));
    repeat (3) send(tick_with(1'b0, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    // Fetch with the count already at zero: no reload even with loop set.
    smp_loop = 1'b1;
    send(tick_with(1'b1, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    repeat (3) send(tick_with(1'b0, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    // Sprite DMA interrupted by a sample halt, then restarted while running.
    send(oam_start(8'hFF));
    repeat (4) send(tick_with(1'b0, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    send(tick_with(1'b1, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    repeat (3) send(tick_with(1'b0, 1'b1, 1'b0, 1'b0, 16'($urandom)));
    send(oam_start(8'h00));
    send(tick_with(1'b0, 1'b1, 1'b0, 1'b0, 16'($urandom)));
  endtask

  // Busy mix of ticks, sample restarts, sprite starts and dropped codes.
  task automatic mixed_run(int count);
    int                sent;
    int                pick;
    dca_pkg::dca_req_t t;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        t = rand_tick(30);
        t.req_type = REQ_UNUSED;
        send(t);
      end else begin
        if (pick < 7) send(new_sample());
        else if (pick < 10) send(oam_start(8'($urandom)));
        else send(rand_tick(30));
        sent++;
      end
    end
  endtask

  // One sprite transfer long enough to finish all 256 bytes, with rare sample halts.
  task automatic oam_sweep(int ticks);
    send(new_sample());
    send(oam_start(8'($urandom)));
    repeat (ticks) send(rand_tick(3));
  endtask

  initial begin
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_run();
    mixed_run(60);
    drain();

    src_idle_pct = 70;
    sink_idle_pct = 15;
    mixed_run(60);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    oam_sweep(600);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (arb_sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: files.f
rtl/dca_pkg.sv
rtl/dca_stream_if.sv
rtl/dma_cycle_arbiter.sv
bench/tb_dma_cycle_arbiter.sv
